/* design/dmdg_pkg.sv */
`default_nettype none

package dmdg_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam int FL_EXT = 4;
    localparam int FL_CRC = 3;
    localparam int FL_SEG = 2;
    localparam int FL_UA  = 1;
    localparam int FL_TID = 0;

    typedef enum logic [3:0] {
        PH_B0     = 4'd0,
        PH_B1     = 4'd1,
        PH_EXT_HI = 4'd2,
        PH_EXT_LO = 4'd3,
        PH_SEG_HI = 4'd4,
        PH_SEG_LO = 4'd5,
        PH_UA     = 4'd6,
        PH_TID_HI = 4'd7,
        PH_TID_LO = 4'd8,
        PH_ADDR   = 4'd9,
        PH_DATA   = 4'd10
    } phase_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_CRC_ERR = 2'd1,
        STATUS_TRUNC   = 2'd2
    } status_t;

    typedef struct packed {
        logic [3:0]  group_type;
        logic [3:0]  continuity_index;
        logic [3:0]  repetition_index;
        logic [15:0] extension_value;
        logic [14:0] segment_number;
        logic        last_segment;
        logic [15:0] transport_ident;
    } hdr_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       data_byte_valid;
        logic       group_end;
        status_t    status;
        hdr_t       hdr;
        logic       transport_ident_present;
    } res_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = b[i] ^ c[15];
            c  = {c[14:0], 1'b0};
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* design/dmdg_core.sv */
`default_nettype none

module dmdg_core (
    input  wire                logic clk,
    input  wire                logic rst_n,
    input  wire                logic accept,
    input  wire                logic [7:0] in_byte,
    input  wire                logic in_last,
    output logic               res_valid,
    output dmdg_pkg::res_t     res
);

    dmdg_pkg::phase_t phase_reg, phase_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       held0_reg, held0_next;
    logic [7:0]       held1_reg, held1_next;
    logic             hd0_reg, hd0_next;
    logic             hd1_reg, hd1_next;
    logic [1:0]       hold_reg, hold_next;
    logic [4:0]       flags_reg, flags_next;
    logic [3:0]       addr_reg, addr_next;
    dmdg_pkg::hdr_t   hdr_reg, hdr_next;
    logic [1:0]       seen_reg, seen_next;

    dmdg_pkg::phase_t ph_p;
    logic [4:0]       fl_p;
    logic [3:0]       ad_p;
    logic [3:0]       ad_dec;
    dmdg_pkg::hdr_t   hd_p;
    logic             is_data;
    logic             crc_on;
    logic             emit;
    logic [7:0]       emit_byte;
    logic [15:0]      crc_s;
    logic [7:0]       h0_s, h1_s;
    logic             d0_s, d1_s;
    logic [1:0]       hc_s;
    logic [1:0]       seen_p;

    // header parse
    always_comb
    begin
        ph_p   = phase_reg;
        fl_p   = flags_reg;
        ad_p   = addr_reg;
        hd_p   = hdr_reg;
        ad_dec = (addr_reg != 4'd0) ? addr_reg - 4'd1 : 4'd0;
        unique case (phase_reg)
            dmdg_pkg::PH_B0:
            begin
                fl_p = {in_byte[7], in_byte[6], in_byte[5], in_byte[4], 1'b0};
                hd_p.group_type = in_byte[3:0];
                ph_p = dmdg_pkg::PH_B1;
            end
            dmdg_pkg::PH_B1:
            begin
                hd_p.continuity_index = in_byte[7:4];
                hd_p.repetition_index = in_byte[3:0];
                if (flags_reg[dmdg_pkg::FL_EXT])
                    ph_p = dmdg_pkg::PH_EXT_HI;
                else if (flags_reg[dmdg_pkg::FL_SEG])
                    ph_p = dmdg_pkg::PH_SEG_HI;
                else if (flags_reg[dmdg_pkg::FL_UA])
                    ph_p = dmdg_pkg::PH_UA;
                else
                    ph_p = dmdg_pkg::PH_DATA;
            end
            dmdg_pkg::PH_EXT_HI:
            begin
                hd_p.extension_value = {in_byte, 8'd0};
                ph_p = dmdg_pkg::PH_EXT_LO;
            end
            dmdg_pkg::PH_EXT_LO:
            begin
                hd_p.extension_value = {hdr_reg.extension_value[15:8], in_byte};
                if (flags_reg[dmdg_pkg::FL_SEG])
                    ph_p = dmdg_pkg::PH_SEG_HI;
                else if (flags_reg[dmdg_pkg::FL_UA])
                    ph_p = dmdg_pkg::PH_UA;
                else
                    ph_p = dmdg_pkg::PH_DATA;
            end
            dmdg_pkg::PH_SEG_HI:
            begin
                hd_p.last_segment   = in_byte[7];
                hd_p.segment_number = {in_byte[6:0], 8'd0};
                ph_p = dmdg_pkg::PH_SEG_LO;
            end
            dmdg_pkg::PH_SEG_LO:
            begin
                hd_p.segment_number = {hdr_reg.segment_number[14:8], in_byte};
                ph_p = flags_reg[dmdg_pkg::FL_UA] ? dmdg_pkg::PH_UA : dmdg_pkg::PH_DATA;
            end
            dmdg_pkg::PH_UA:
            begin
                if (in_byte[4])
                begin
                    fl_p[dmdg_pkg::FL_TID] = 1'b1;
                    ad_p = (in_byte[3:0] >= 4'd2) ? in_byte[3:0] - 4'd2 : 4'd0;
                    ph_p = dmdg_pkg::PH_TID_HI;
                end
                else
                begin
                    ad_p = in_byte[3:0];
                    ph_p = (in_byte[3:0] != 4'd0) ? dmdg_pkg::PH_ADDR : dmdg_pkg::PH_DATA;
                end
            end
            dmdg_pkg::PH_TID_HI:
            begin
                hd_p.transport_ident = {in_byte, 8'd0};
                ph_p = dmdg_pkg::PH_TID_LO;
            end
            dmdg_pkg::PH_TID_LO:
            begin
                hd_p.transport_ident = {hdr_reg.transport_ident[15:8], in_byte};
                ph_p = (addr_reg != 4'd0) ? dmdg_pkg::PH_ADDR : dmdg_pkg::PH_DATA;
            end
            dmdg_pkg::PH_ADDR:
            begin
                ad_p = ad_dec;
                if (ad_dec == 4'd0)
                    ph_p = dmdg_pkg::PH_DATA;
            end
            default:
            begin
                ph_p = dmdg_pkg::PH_DATA;
            end
        endcase
    end

    // crc window, emit and result
    always_comb
    begin
        is_data   = (phase_reg == dmdg_pkg::PH_DATA);
        seen_p    = (is_data && seen_reg != 2'd2) ? seen_reg + 2'd1 : seen_reg;
        crc_on    = fl_p[dmdg_pkg::FL_CRC];
        emit      = 1'b0;
        emit_byte = 8'd0;
        crc_s     = crc_reg;
        h0_s      = held0_reg;
        h1_s      = held1_reg;
        d0_s      = hd0_reg;
        d1_s      = hd1_reg;
        hc_s      = hold_reg;
        if (hold_reg == 2'd2)
        begin
            crc_s = dmdg_pkg::crc16_byte(crc_reg, held0_reg);
            if (hd0_reg && crc_on)
            begin
                emit      = 1'b1;
                emit_byte = held0_reg;
            end
            h0_s = held1_reg;
            d0_s = hd1_reg;
            hc_s = 2'd1;
        end
        if (is_data && !crc_on)
        begin
            emit      = 1'b1;
            emit_byte = in_byte;
        end

        res_valid                   = accept && (emit || in_last);
        res                         = '0;
        res.data_byte               = emit ? emit_byte : 8'd0;
        res.data_byte_valid         = emit;
        res.status                  = dmdg_pkg::STATUS_OK;
        if (in_last)
        begin
            res.group_end = 1'b1;
            res.hdr       = hd_p;
            res.transport_ident_present = fl_p[dmdg_pkg::FL_TID];
            if (ph_p != dmdg_pkg::PH_DATA || (crc_on && seen_p != 2'd2))
                res.status = dmdg_pkg::STATUS_TRUNC;
            else if (crc_on && crc_s != ~{h0_s, in_byte})
                res.status = dmdg_pkg::STATUS_CRC_ERR;
        end
    end

    // next register values
    always_comb
    begin
        phase_next = phase_reg;
        crc_next   = crc_reg;
        held0_next = held0_reg;
        held1_next = held1_reg;
        hd0_next   = hd0_reg;
        hd1_next   = hd1_reg;
        hold_next  = hold_reg;
        flags_next = flags_reg;
        addr_next  = addr_reg;
        hdr_next   = hdr_reg;
        seen_next  = seen_reg;
        if (accept)
        begin
            if (in_last)
            begin
                phase_next = dmdg_pkg::PH_B0;
                crc_next   = dmdg_pkg::CRC_INIT;
                held0_next = 8'd0;
                held1_next = 8'd0;
                hd0_next   = 1'b0;
                hd1_next   = 1'b0;
                hold_next  = 2'd0;
                flags_next = 5'd0;
                addr_next  = 4'd0;
                hdr_next   = '0;
                seen_next  = 2'd0;
            end
            else
            begin
                phase_next = ph_p;
                crc_next   = crc_s;
                flags_next = fl_p;
                addr_next  = ad_p;
                hdr_next   = hd_p;
                seen_next  = seen_p;
                held0_next = h0_s;
                held1_next = h1_s;
                hd0_next   = d0_s;
                hd1_next   = d1_s;
                if (hc_s == 2'd0)
                begin
                    held0_next = in_byte;
                    hd0_next   = is_data;
                end
                else
                begin
                    held1_next = in_byte;
                    hd1_next   = is_data;
                end
                hold_next = hc_s + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dmdg_pkg::PH_B0;
            crc_reg   <= dmdg_pkg::CRC_INIT;
            held0_reg <= 8'd0;
            held1_reg <= 8'd0;
            hd0_reg   <= 1'b0;
            hd1_reg   <= 1'b0;
            hold_reg  <= 2'd0;
            flags_reg <= 5'd0;
            addr_reg  <= 4'd0;
            hdr_reg   <= '0;
            seen_reg  <= 2'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            crc_reg   <= crc_next;
            held0_reg <= held0_next;
            held1_reg <= held1_next;
            hd0_reg   <= hd0_next;
            hd1_reg   <= hd1_next;
            hold_reg  <= hold_next;
            flags_reg <= flags_next;
            addr_reg  <= addr_next;
            hdr_reg   <= hdr_next;
            seen_reg  <= seen_next;
        end
    end

endmodule

`default_nettype wire

/* design/dmdg_out_buf.sv */
`default_nettype none

module dmdg_out_buf (
    input  wire                logic clk,
    input  wire                logic rst_n,
    input  wire                logic push,
    input  wire dmdg_pkg::res_t push_data,
    input  wire                logic pop,
    output logic               not_full,
    output logic               out_valid,
    output dmdg_pkg::res_t     out_data
);

    dmdg_pkg::res_t entry_reg [2];
    logic           wr_reg, wr_next;
    logic           rd_reg, rd_next;
    logic [1:0]     count_reg, count_next;

    always_comb
    begin
        wr_next    = push ? ~wr_reg : wr_reg;
        rd_next    = pop ? ~rd_reg : rd_reg;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
        not_full   = (count_reg != 2'd2);
        out_valid  = (count_reg != 2'd0);
        out_data   = entry_reg[rd_reg];
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

/* design/dab_msc_data_group_parser.sv */
// channel   dir  tdata                                      tuser            tlast
// s_axis    in   [7:0] in_byte                              -                in_last
// m_axis    out  data_byte, status, header fields (71 bits) data_byte_valid  group_end
//
// one byte accepted per cycle while s_tready is high; the parse and crc update for a byte finish
// in the cycle it is accepted, and its result is written into a two-entry output buffer
// a result is offered on m_axis from the cycle after its byte is accepted,
// behind any result still waiting in the buffer
// s_tready drops only while both output buffer entries wait to be taken
// rst_n clears the parser to expect header byte 0 with the crc at its start value
`default_nettype none

module dab_msc_data_group_parser (
    input  wire  logic        clk,
    input  wire  logic        rst_n,
    input  wire  logic        s_tvalid,
    output logic              s_tready,
    input  wire  logic [7:0]  s_tdata,  // in_byte
    input  wire  logic        s_tlast,  // in_last
    output logic              m_tvalid,
    input  wire  logic        m_tready,
    output logic [71:0]       m_tdata,  // data_byte, status, group_type, continuity_index,
                                        // repetition_index, extension_value, segment_number,
                                        // last_segment, transport_ident,
                                        // transport_ident_present, zero pad
    output logic              m_tuser,  // data_byte_valid
    output logic              m_tlast   // group_end
);

    logic           accept;
    logic           res_valid;
    dmdg_pkg::res_t res;
    logic           not_full;
    dmdg_pkg::res_t out_data;

    assign s_tready = not_full;
    assign accept   = s_tvalid && not_full;

    dmdg_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .res_valid (res_valid),
        .res       (res)
    );

    dmdg_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .pop       (m_tvalid && m_tready),
        .not_full  (not_full),
        .out_valid (m_tvalid),
        .out_data  (out_data)
    );

    assign m_tdata = {1'b0,
                      out_data.transport_ident_present,
                      out_data.hdr.transport_ident,
                      out_data.hdr.last_segment,
                      out_data.hdr.segment_number,
                      out_data.hdr.extension_value,
                      out_data.hdr.repetition_index,
                      out_data.hdr.continuity_index,
                      out_data.hdr.group_type,
                      out_data.status,
                      out_data.data_byte};
    assign m_tuser = out_data.data_byte_valid;
    assign m_tlast = out_data.group_end;

endmodule

`default_nettype wire

/* tb/dab_msc_data_group_parser_tb.sv */
`timescale 1ns / 1ps

module dab_msc_data_group_parser_tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int ITEM_TARGET  = 1100;
    localparam int HOLD_CYCLES  = 60;

    typedef enum logic [1:0] {
        FILL_NONE,
        FILL_CRC_HI,
        FILL_CRC_LO
    } crc_fill_t;

    typedef struct packed {
        logic [7:0]        data_byte;
        logic              data_valid;
        logic              group_end;
        dmdg_pkg::status_t status;
        logic [3:0]        group_type;
        logic [3:0]        cont_idx;
        logic [3:0]        rep_idx;
        logic [15:0]       ext_val;
        logic [14:0]       seg_num;
        logic              seg_last;
        logic [15:0]       tid;
        logic              tid_present;
    } parser_out_t;

    typedef struct {
        logic [7:0]        in_byte;
        logic              in_last;
        crc_fill_t         fill;
        logic              typed;
        logic [7:0]        want_byte;
        logic              want_valid;
        dmdg_pkg::status_t want_status;
        logic [3:0]        want_type;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    // parser state mirror
    dmdg_pkg::phase_t gp_phase;
    logic [15:0]      gp_crc;
    logic [7:0]       win_byte [2];
    logic             win_is_data [2];
    int               win_count;
    logic [4:0]       gp_flags;
    logic [3:0]       addr_left;
    dmdg_pkg::hdr_t   gp_hdr;
    logic [1:0]       data_count;

    parser_out_t parser_results_q [$];
    stim_row_t   rows [$];

    int err_count   = 0;
    int items_sent  = 0;
    int cycle_count = 0;
    int burst_left  = 0;
    int gap_max     = 6;
    int holds_asked = 0;
    int holds_done  = 0;

    dab_msc_data_group_parser i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] r;
        r = c;
        for (int k = 7; k >= 0; k--)
            r = (r[15] ^ d[k]) ? ({r[14:0], 1'b0} ^ dmdg_pkg::CRC_POLY) : {r[14:0], 1'b0};
        return r;
    endfunction

    function automatic void clear_parser();
        gp_phase       = dmdg_pkg::PH_B0;
        gp_crc         = dmdg_pkg::CRC_INIT;
        win_byte[0]    = 8'h00;
        win_byte[1]    = 8'h00;
        win_is_data[0] = 1'b0;
        win_is_data[1] = 1'b0;
        win_count      = 0;
        gp_flags       = '0;
        addr_left      = '0;
        gp_hdr         = '0;
        data_count     = '0;
    endfunction

    function automatic dmdg_pkg::phase_t phase_after_tid();
        return (addr_left > 0) ? dmdg_pkg::PH_ADDR : dmdg_pkg::PH_DATA;
    endfunction

    function automatic dmdg_pkg::phase_t phase_after_seg();
        return gp_flags[dmdg_pkg::FL_UA] ? dmdg_pkg::PH_UA : dmdg_pkg::PH_DATA;
    endfunction

    function automatic dmdg_pkg::phase_t phase_after_ext();
        return gp_flags[dmdg_pkg::FL_SEG] ? dmdg_pkg::PH_SEG_HI : phase_after_seg();
    endfunction

    // returns 1 when the byte produces an output item
    function automatic logic advance_parser(input logic [7:0] b, input logic l,
                                            output parser_out_t r);
        logic              is_data;
        logic              crc_on;
        logic              emit;
        logic [7:0]        eb;
        dmdg_pkg::status_t st;
        is_data = (gp_phase == dmdg_pkg::PH_DATA);
        emit    = 1'b0;
        eb      = 8'h00;
        r       = '0;
        if (is_data && data_count < 2)
            data_count++;
        case (gp_phase)
            dmdg_pkg::PH_B0:
            begin
                gp_flags                   = '0;
                gp_flags[dmdg_pkg::FL_EXT] = b[7];
                gp_flags[dmdg_pkg::FL_CRC] = b[6];
                gp_flags[dmdg_pkg::FL_SEG] = b[5];
                gp_flags[dmdg_pkg::FL_UA]  = b[4];
                gp_hdr.group_type          = b[3:0];
                gp_phase                   = dmdg_pkg::PH_B1;
            end
            dmdg_pkg::PH_B1:
            begin
                gp_hdr.continuity_index = b[7:4];
                gp_hdr.repetition_index = b[3:0];
                gp_phase = gp_flags[dmdg_pkg::FL_EXT] ? dmdg_pkg::PH_EXT_HI : phase_after_ext();
            end
            dmdg_pkg::PH_EXT_HI:
            begin
                gp_hdr.extension_value = {b, 8'h00};
                gp_phase = dmdg_pkg::PH_EXT_LO;
            end
            dmdg_pkg::PH_EXT_LO:
            begin
                gp_hdr.extension_value[7:0] = b;
                gp_phase = phase_after_ext();
            end
            dmdg_pkg::PH_SEG_HI:
            begin
                gp_hdr.last_segment   = b[7];
                gp_hdr.segment_number = {b[6:0], 8'h00};
                gp_phase = dmdg_pkg::PH_SEG_LO;
            end
            dmdg_pkg::PH_SEG_LO:
            begin
                gp_hdr.segment_number[7:0] = b;
                gp_phase = phase_after_seg();
            end
            dmdg_pkg::PH_UA:
            begin
                if (b[4])
                begin
                    gp_flags[dmdg_pkg::FL_TID] = 1'b1;
                    addr_left = (b[3:0] >= 4'd2) ? b[3:0] - 4'd2 : 4'd0;
                    gp_phase  = dmdg_pkg::PH_TID_HI;
                end
                else
                begin
                    addr_left = b[3:0];
                    gp_phase  = phase_after_tid();
                end
            end
            dmdg_pkg::PH_TID_HI:
            begin
                gp_hdr.transport_ident = {b, 8'h00};
                gp_phase = dmdg_pkg::PH_TID_LO;
            end
            dmdg_pkg::PH_TID_LO:
            begin
                gp_hdr.transport_ident[7:0] = b;
                gp_phase = phase_after_tid();
            end
            dmdg_pkg::PH_ADDR:
            begin
                if (addr_left > 0)
                    addr_left--;
                if (addr_left == 0)
                    gp_phase = dmdg_pkg::PH_DATA;
            end
            default:
                gp_phase = dmdg_pkg::PH_DATA;
        endcase
        crc_on = gp_flags[dmdg_pkg::FL_CRC];

        // oldest byte of the two-byte window is now known not to be crc
        if (win_count >= 2)
        begin
            gp_crc = crc_next(gp_crc, win_byte[0]);
            if (win_is_data[0] && crc_on)
            begin
                emit = 1'b1;
                eb   = win_byte[0];
            end
            win_byte[0]    = win_byte[1];
            win_is_data[0] = win_is_data[1];
            win_count      = 1;
        end
        if (is_data && !crc_on)
        begin
            emit = 1'b1;
            eb   = b;
        end

        if (!l)
        begin
            win_byte[win_count]    = b;
            win_is_data[win_count] = is_data;
            win_count++;
            r.data_byte  = eb;
            r.data_valid = emit;
            return emit;
        end

        st = dmdg_pkg::STATUS_OK;
        if (gp_phase != dmdg_pkg::PH_DATA || (crc_on && data_count < 2))
            st = dmdg_pkg::STATUS_TRUNC;
        else if (crc_on && gp_crc != ~{win_byte[0], b})
            st = dmdg_pkg::STATUS_CRC_ERR;
        r.data_byte   = eb;
        r.data_valid  = emit;
        r.group_end   = 1'b1;
        r.status      = st;
        r.group_type  = gp_hdr.group_type;
        r.cont_idx    = gp_hdr.continuity_index;
        r.rep_idx     = gp_hdr.repetition_index;
        r.ext_val     = gp_hdr.extension_value;
        r.seg_num     = gp_hdr.segment_number;
        r.seg_last    = gp_hdr.last_segment;
        r.tid         = gp_hdr.transport_ident;
        r.tid_present = gp_flags[dmdg_pkg::FL_TID];
        clear_parser();
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        err_count++;
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task automatic add_row(input logic [7:0] b, input logic l, input crc_fill_t f);
        stim_row_t row;
        row.in_byte     = b;
        row.in_last     = l;
        row.fill        = f;
        row.typed       = 1'b0;
        row.want_byte   = 8'h00;
        row.want_valid  = 1'b0;
        row.want_status = dmdg_pkg::STATUS_OK;
        row.want_type   = 4'h0;
        rows.push_back(row);
    endtask

    task automatic add_checked_row(input logic [7:0] b, input logic l, input logic [7:0] wb,
                                   input logic wv, input dmdg_pkg::status_t ws,
                                   input logic [3:0] wt);
        stim_row_t row;
        row.in_byte     = b;
        row.in_last     = l;
        row.fill        = FILL_NONE;
        row.typed       = 1'b1;
        row.want_byte   = wb;
        row.want_valid  = wv;
        row.want_status = ws;
        row.want_type   = wt;
        rows.push_back(row);
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic l, input logic typed,
                             input parser_out_t want);
        parser_out_t r;
        logic        got;
        int          gap;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        got = advance_parser(b, l, r);
        if (typed)
            parser_results_q.push_back(want);
        else if (got)
            parser_results_q.push_back(r);
        items_sent++;
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (parser_results_q.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random_group(input logic bulk);
        logic [7:0]  grp [$];
        logic [7:0]  b0;
        logic [7:0]  ua;
        logic [15:0] c;
        logic [7:0]  lo;
        int          kind;
        int          n;
        int          nd;
        parser_out_t none;
        none = '0;
        kind = bulk ? 99 : $urandom_range(0, 99);
        gap_max    = (bulk || $urandom_range(0, 3) == 0) ? 0 : 6;
        burst_left = $urandom_range(1, 24);
        if (kind < 8)
        begin
            // noise
            n = $urandom_range(1, 12);
            repeat (n) grp.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            b0 = 8'($urandom_range(0, 255));
            if (bulk)
                b0[7:4] = 4'h0;
            grp.push_back(b0);
            grp.push_back(8'($urandom_range(0, 255)));
            if (b0[7])
                repeat (2) grp.push_back(8'($urandom_range(0, 255)));
            if (b0[5])
                repeat (2) grp.push_back(8'($urandom_range(0, 255)));
            if (b0[4])
            begin
                ua = 8'($urandom_range(0, 255));
                grp.push_back(ua);
                if (ua[4])
                begin
                    repeat (2) grp.push_back(8'($urandom_range(0, 255)));
                    n = (ua[3:0] >= 2) ? ua[3:0] - 2 : 0;
                end
                else
                    n = ua[3:0];
                repeat (n) grp.push_back(8'($urandom_range(0, 255)));
            end
            if (bulk)
                nd = 40;
            else if ($urandom_range(0, 9) == 0)
                nd = $urandom_range(0, 40);
            else
                nd = $urandom_range(0, 8);
            repeat (nd) grp.push_back(8'($urandom_range(0, 255)));
            if (b0[6])
            begin
                c = dmdg_pkg::CRC_INIT;
                foreach (grp[i])
                    c = crc_next(c, grp[i]);
                lo = ~c[7:0];
                if ($urandom_range(0, 9) == 0)
                    lo = lo ^ (8'h01 << $urandom_range(0, 7));
                grp.push_back(~c[15:8]);
                grp.push_back(lo);
            end
            if (kind < 16)
            begin
                // group cut short at a random point
                n = $urandom_range(1, grp.size());
                while (grp.size() > n)
                    void'(grp.pop_back());
            end
        end
        foreach (grp[i])
            send_byte(grp[i], i == grp.size() - 1, 1'b0, none);
    endtask

    // receiver: rotating stall mask, plus long hold-offs on request
    initial
    begin : receiver
        logic [7:0] pat;
        int         win;
        int         n;
        pat = 8'hFF;
        win = 0;
        forever
        begin
            @(negedge clk);
            if (holds_done != holds_asked)
            begin
                holds_done++;
                m_tready <= 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++)
                    @(negedge clk);
            end
            else
            begin
                if (win == 0)
                begin
                    pat = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(0, 255));
                    win = $urandom_range(16, 80);
                end
                win--;
                pat = {pat[0], pat[7:1]};
                m_tready <= pat[0];
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        parser_out_t got;
        parser_out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.data_byte   = m_tdata[7:0];
            got.status      = dmdg_pkg::status_t'(m_tdata[9:8]);
            got.group_type  = m_tdata[13:10];
            got.cont_idx    = m_tdata[17:14];
            got.rep_idx     = m_tdata[21:18];
            got.ext_val     = m_tdata[37:22];
            got.seg_num     = m_tdata[52:38];
            got.seg_last    = m_tdata[53];
            got.tid         = m_tdata[69:54];
            got.tid_present = m_tdata[70];
            got.data_valid  = m_tuser;
            got.group_end   = m_tlast;
            if (parser_results_q.size() == 0)
                report_mismatch("output item with none expected");
            else
            begin
                want = parser_results_q.pop_front();
                compare_field("data_byte", got.data_byte, want.data_byte);
                compare_field("data_byte_valid", got.data_valid, want.data_valid);
                compare_field("group_end", got.group_end, want.group_end);
                compare_field("status", got.status, want.status);
                compare_field("group_type", got.group_type, want.group_type);
                compare_field("continuity_index", got.cont_idx, want.cont_idx);
                compare_field("repetition_index", got.rep_idx, want.rep_idx);
                compare_field("extension_value", got.ext_val, want.ext_val);
                compare_field("segment_number", got.seg_num, want.seg_num);
                compare_field("last_segment", got.seg_last, want.seg_last);
                compare_field("transport_ident", got.tid, want.tid);
                compare_field("transport_ident_present", got.tid_present, want.tid_present);
            end
        end
    end

    initial
    begin : stimulus
        logic [15:0] tx_crc;
        logic [7:0]  b;
        parser_out_t want;
        logic        mid_hold_done;
        int          n;
        tx_crc        = dmdg_pkg::CRC_INIT;
        mid_hold_done = 1'b0;
        clear_parser();

        // header cut short after one byte
        add_checked_row(8'hFF, 1'b1, 8'h00, 1'b0, dmdg_pkg::STATUS_TRUNC, 4'hF);
        // bare group, no crc, one data byte
        add_row(8'h00, 1'b0, FILL_NONE);
        add_row(8'h00, 1'b0, FILL_NONE);
        add_checked_row(8'hAB, 1'b1, 8'hAB, 1'b1, dmdg_pkg::STATUS_OK, 4'h0);
        // every header part at its maximum, one address byte, good crc
        add_row(8'hFF, 1'b0, FILL_NONE);
        add_row(8'hFF, 1'b0, FILL_NONE);
        add_row(8'hFF, 1'b0, FILL_NONE);
        add_row(8'hFF, 1'b0, FILL_NONE);
        add_row(8'hFF, 1'b0, FILL_NONE);
        add_row(8'hFF, 1'b0, FILL_NONE);
        add_row(8'h13, 1'b0, FILL_NONE);
        add_row(8'hFF, 1'b0, FILL_NONE);
        add_row(8'hFF, 1'b0, FILL_NONE);
        add_row(8'h55, 1'b0, FILL_NONE);
        add_row(8'h00, 1'b0, FILL_NONE);
        add_row(8'hFF, 1'b0, FILL_NONE);
        add_row(8'h00, 1'b0, FILL_CRC_HI);
        add_row(8'h00, 1'b1, FILL_CRC_LO);
        // transport id with length indicator one, crc flag, too few bytes after header
        add_row(8'h50, 1'b0, FILL_NONE);
        add_row(8'h0A, 1'b0, FILL_NONE);
        add_row(8'h11, 1'b0, FILL_NONE);
        add_row(8'h12, 1'b0, FILL_NONE);
        add_row(8'h34, 1'b0, FILL_NONE);
        add_row(8'h99, 1'b1, FILL_NONE);

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        burst_left = $urandom_range(1, 24);

        foreach (rows[i])
        begin
            b = rows[i].in_byte;
            if (rows[i].fill == FILL_CRC_HI)
                b = ~tx_crc[15:8];
            else if (rows[i].fill == FILL_CRC_LO)
                b = ~tx_crc[7:0];
            else
                tx_crc = crc_next(tx_crc, b);
            want = '0;
            want.data_byte  = rows[i].want_byte;
            want.data_valid = rows[i].want_valid;
            want.group_end  = rows[i].in_last;
            want.status     = rows[i].want_status;
            want.group_type = rows[i].want_type;
            send_byte(b, rows[i].in_last, rows[i].typed, want);
            if (rows[i].in_last)
                tx_crc = dmdg_pkg::CRC_INIT;
        end

        // long receiver hold while a long data group keeps coming
        holds_asked++;
        send_random_group(1'b1);
        drain_results();

        while (items_sent < ITEM_TARGET)
        begin
            if (!mid_hold_done && items_sent > ITEM_TARGET / 2)
            begin
                mid_hold_done = 1'b1;
                drain_results();
                holds_asked++;
                send_random_group(1'b1);
            end
            send_random_group(1'b0);
        end

        s_tvalid <= 1'b0;
        n = 0;
        while (parser_results_q.size() != 0 && n < 5000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (10) @(posedge clk);
        if (parser_results_q.size() != 0)
            report_mismatch($sformatf("%0d output items never arrived",
                                      parser_results_q.size()));
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* filelist.f */
design/dmdg_pkg.sv
design/dmdg_core.sv
design/dmdg_out_buf.sv
design/dab_msc_data_group_parser.sv
tb/dab_msc_data_group_parser_tb.sv
